@@ hdl/weighted_nearest_point_search_macros.svh @@
// assertion macros shared by the search block
`ifndef WEIGHTED_NEAREST_POINT_SEARCH_MACROS_SVH
`define WEIGHTED_NEAREST_POINT_SEARCH_MACROS_SVH

// condition implies consequence in the same cycle
`define WNPS_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define WNPS_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wnps_pkg.sv @@
// types, constants and codes of the weighted nearest point search
`timescale 1ns / 1ps

package wnps_pkg;

    localparam int IDX_W               = 6;
    localparam int COORD_W             = 16;
    localparam int ELEV_W              = 10;
    localparam int WEIGHT_W            = 10;
    localparam int SUM_W               = 47;
    localparam int DIST_W              = 38;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 10;
    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic [IDX_W-1:0]    RESET_ENTRY_COUNT = 6'd35;
    localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_TEMP = 10'd384;
    localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_MOIST = 10'd384;
    localparam logic [WEIGHT_W-1:0] RESET_WEIGHT_ELEV = 10'd205;
    localparam logic [DIST_W-1:0]   DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic
    {
        CMD_WRITE    = 1'b0,
        CMD_CLASSIFY = 1'b1
    } wnps_cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        CFG_ENTRY_COUNT = 2'd0,
        CFG_WEIGHT_TEMP = 2'd1,
        CFG_WEIGHT_MOIST = 2'd2,
        CFG_WEIGHT_ELEV = 2'd3
    } wnps_cfg_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } wnps_state_t;

    typedef struct packed
    {
        logic signed [COORD_W-1:0] temperature;
        logic signed [COORD_W-1:0] moisture;
        logic signed [ELEV_W-1:0]  elevation;
    } wnps_point_t;

    typedef struct packed
    {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  idx;
    } wnps_tag_t;

    typedef struct packed
    {
        logic [WEIGHT_W-1:0] temperature;
        logic [WEIGHT_W-1:0] moisture;
        logic [WEIGHT_W-1:0] elevation;
    } wnps_weights_t;

endpackage

@@ hdl/wnps_dist.sv @@
// pipelined weighted squared distance between a sample and one table entry
`timescale 1ns / 1ps

module wnps_dist
    import wnps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  wnps_tag_t                 tag_in,
    input  wnps_point_t               entry,
    input  wnps_point_t               sample,
    input  wnps_weights_t             weights,
    output wnps_tag_t                 tag_out,
    output logic [SUM_W-1:0]          sum_out
);

    wnps_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    logic signed [COORD_W:0] diff_t, diff_m;
    logic signed [ELEV_W:0]  diff_e;
    logic [COORD_W-1:0]      abs_t_next, abs_m_next;
    logic [ELEV_W-1:0]       abs_e_next;

    logic [COORD_W-1:0]      abs_t_reg, abs_m_reg;
    logic [ELEV_W-1:0]       abs_e_reg;
    logic [2*COORD_W-1:0]    sq_t_reg, sq_m_reg;
    logic [2*ELEV_W-1:0]     sq_e_reg;
    logic [2*COORD_W+WEIGHT_W-1:0] prod_t_reg, prod_m_reg;
    logic [2*ELEV_W+WEIGHT_W-1:0]  prod_e_reg;
    logic [SUM_W-1:0]        sum_reg;

    always_comb
    begin
        logic signed [COORD_W:0] neg_t, neg_m;
        logic signed [ELEV_W:0]  neg_e;
        diff_t = {sample.temperature[COORD_W-1], sample.temperature}
               - {entry.temperature[COORD_W-1], entry.temperature};
        diff_m = {sample.moisture[COORD_W-1], sample.moisture}
               - {entry.moisture[COORD_W-1], entry.moisture};
        diff_e = {sample.elevation[ELEV_W-1], sample.elevation}
               - {entry.elevation[ELEV_W-1], entry.elevation};
        neg_t = -diff_t;
        neg_m = -diff_m;
        neg_e = -diff_e;
        abs_t_next = diff_t[COORD_W] ? neg_t[COORD_W-1:0] : diff_t[COORD_W-1:0];
        abs_m_next = diff_m[COORD_W] ? neg_m[COORD_W-1:0] : diff_m[COORD_W-1:0];
        abs_e_next = diff_e[ELEV_W] ? neg_e[ELEV_W-1:0] : diff_e[ELEV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_t_reg  <= abs_t_next;
        abs_m_reg  <= abs_m_next;
        abs_e_reg  <= abs_e_next;
        sq_t_reg   <= abs_t_reg * abs_t_reg;
        sq_m_reg   <= abs_m_reg * abs_m_reg;
        sq_e_reg   <= abs_e_reg * abs_e_reg;
        prod_t_reg <= sq_t_reg * weights.temperature;
        prod_m_reg <= sq_m_reg * weights.moisture;
        prod_e_reg <= sq_e_reg * weights.elevation;
        // elevation difference carries a factor of 256, squared gives 16 bits of shift
        sum_reg    <= SUM_W'(prod_t_reg) + SUM_W'(prod_m_reg)
                    + SUM_W'({prod_e_reg, 16'd0});
    end

    assign tag_out = tag4_reg;
    assign sum_out = sum_reg;

endmodule

@@ hdl/weighted_nearest_point_search.sv @@
// top level of the weighted nearest point search: table memory, walk control, best tracking
//
// A request is taken at a rising edge with start high and busy low. With command
// low it writes entry_index of the point table in that edge and busy stays low, so
// another request may follow in the next cycle. With command high it classifies the
// sample fields: the block walks entries 1 to entry_count, clamped to TABLE_DEPTH - 1, one
// memory read a cycle, through a four stage distance pipeline, and busy stays high until
// the answer goes out. The result appears on best_index and best_distance for one cycle
// with done high, once the last entry has passed the read register, the four distance
// stages and the result register; an empty search answers in the next cycle. A classify
// request holds the block until its result is out. Results cannot be held off by the receiver.
// Registers are written over cfg_valid, cfg_ready, cfg_index and cfg_data while idle.
// Reset restores the register defaults and clears all control state; the table
// holds no defined contents until written and needs no clearing pass.
`timescale 1ns / 1ps

module weighted_nearest_point_search
    import wnps_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       command,
    input  logic [IDX_W-1:0]           entry_index,
    input  logic signed [COORD_W-1:0]  entry_temperature,
    input  logic signed [COORD_W-1:0]  entry_moisture,
    input  logic signed [ELEV_W-1:0]   entry_elevation,
    input  logic signed [COORD_W-1:0]  sample_temperature,
    input  logic signed [COORD_W-1:0]  sample_moisture,
    input  logic signed [ELEV_W-1:0]   sample_elevation,
    output logic                       done,
    output logic [IDX_W-1:0]           best_index,
    output logic [DIST_W-1:0]          best_distance,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

`include "weighted_nearest_point_search_macros.svh"

    localparam int AddrW   = $clog2(TABLE_DEPTH);
    localparam int LastMax = TABLE_DEPTH - 1;
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

    wnps_state_t state_reg, state_next;

    logic [IDX_W-1:0] entry_count_reg;
    wnps_weights_t    weights_reg;

    wnps_point_t      mem [TABLE_DEPTH];
    wnps_point_t      rd_data_reg;
    wnps_point_t      sample_reg;
    wnps_tag_t        rd_tag_reg, rd_tag_next;

    logic [IDX_W-1:0] walk_idx_reg, last_reg, last_clamp;
    logic             accept, accept_write, accept_classify, walking;

    wnps_tag_t        cmp_tag;
    logic [SUM_W-1:0] cmp_sum;
    logic [SUM_W-1:0] best_sum_reg, best_sum_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [DIST_W:0]  dist_wide;

    logic             done_reg;
    logic [IDX_W-1:0] best_index_reg;
    logic [DIST_W-1:0] best_distance_reg;

    assign accept          = start && !busy;
    assign accept_write    = accept && (command == CMD_WRITE);
    assign accept_classify = accept && (command == CMD_CLASSIFY);
    assign last_clamp      = (int'(entry_count_reg) > LastMax) ? IDX_W'(LastMax)
                                                               : entry_count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_classify && (last_clamp != '0))
                    state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (walk_idx_reg == last_reg)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (cmp_tag.valid && cmp_tag.last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        busy      = 1'b1;
        walking   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_WALK:  walking = 1'b1;
            ST_DRAIN: walking = 1'b0;
            default:  busy = 1'b1;
        endcase
        cfg_ready = !busy && !start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg       <= RESET_ENTRY_COUNT;
            weights_reg.temperature <= RESET_WEIGHT_TEMP;
            weights_reg.moisture  <= RESET_WEIGHT_MOIST;
            weights_reg.elevation <= RESET_WEIGHT_ELEV;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (wnps_cfg_t'(cfg_index))
                CFG_ENTRY_COUNT:  entry_count_reg <= cfg_data[IDX_W-1:0];
                CFG_WEIGHT_TEMP:  weights_reg.temperature <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_MOIST: weights_reg.moisture <= cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_ELEV:  weights_reg.elevation <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // walk counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_idx_reg <= '0;
            last_reg     <= '0;
        end
        else if (accept_classify)
        begin
            walk_idx_reg <= FIRST_IDX;
            last_reg     <= last_clamp;
        end
        else if (walking)
            walk_idx_reg <= walk_idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (accept_classify)
        begin
            sample_reg.temperature <= sample_temperature;
            sample_reg.moisture    <= sample_moisture;
            sample_reg.elevation   <= sample_elevation;
        end
    end

    // point table
    always_ff @(posedge clk)
    begin
        if (accept_write && (int'(entry_index) < TABLE_DEPTH))
            mem[AddrW'(entry_index)] <= '{entry_temperature, entry_moisture,
                                          entry_elevation};
        rd_data_reg <= mem[AddrW'(walk_idx_reg)];
    end

    always_comb
    begin
        rd_tag_next.valid = walking;
        rd_tag_next.last  = walking && (walk_idx_reg == last_reg);
        rd_tag_next.idx   = walk_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_tag_reg <= '0;
        else
            rd_tag_reg <= rd_tag_next;
    end

    wnps_dist u_dist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (rd_tag_reg),
        .entry   (rd_data_reg),
        .sample  (sample_reg),
        .weights (weights_reg),
        .tag_out (cmp_tag),
        .sum_out (cmp_sum)
    );

    // best tracking, first strictly smaller wins
    always_comb
    begin
        if ((cmp_tag.idx == FIRST_IDX) || (cmp_sum < best_sum_reg))
        begin
            best_sum_next = cmp_sum;
            best_idx_next = cmp_tag.idx;
        end
        else
        begin
            best_sum_next = best_sum_reg;
            best_idx_next = best_idx_reg;
        end
        dist_wide = best_sum_next[SUM_W-1:8];
    end

    always_ff @(posedge clk)
    begin
        if (cmp_tag.valid)
        begin
            best_sum_reg <= best_sum_next;
            best_idx_reg <= best_idx_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (cmp_tag.valid && cmp_tag.last)
                     || (accept_classify && (last_clamp == '0));
    end

    always_ff @(posedge clk)
    begin
        priority if (cmp_tag.valid && cmp_tag.last)
        begin
            best_index_reg    <= best_idx_next;
            best_distance_reg <= dist_wide[DIST_W] ? DIST_MAX : dist_wide[DIST_W-1:0];
        end
        else if (accept_classify)
        begin
            best_index_reg    <= FIRST_IDX;
            best_distance_reg <= DIST_MAX;
        end
    end

    assign done          = done_reg;
    assign best_index    = best_index_reg;
    assign best_distance = best_distance_reg;

    `WNPS_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy,
        "result strobe while a search is still running")
    `WNPS_ASSERT_NOW(a_done_index, clk, rst_n, done, best_index != '0,
        "result index zero")
    `WNPS_ASSERT_NEXT(a_empty_answer, clk, rst_n, accept_classify && (last_clamp == '0),
        done && (best_distance == DIST_MAX),
        "empty search gave no saturated answer")
    `WNPS_ASSERT_NOW(a_walk_bound, clk, rst_n, walking,
        (walk_idx_reg != '0) && (walk_idx_reg <= last_reg),
        "walk index outside searched range")
    `WNPS_ASSERT_NOW(a_pipe_busy, clk, rst_n, cmp_tag.valid, busy,
        "distance arrived while idle")

endmodule
